// ===== hw/rtl/bfac_pkg.sv =====
// shared constants and the table size clamp for the bloom filter address check
package bfac_pkg;

  localparam int MAX_BITS   = 65536;                  // bits in the filter store
  localparam int ADDR_BITS  = 64;                     // address bits that are hashed
  localparam int ADDR_FIELD_W = 64;                   // width of the address field
  localparam int CFG_W      = 17;                     // width of the table size register
  localparam int IDX_W      = $clog2(MAX_BITS);       // bit index into the store
  localparam int SIZE_W     = $clog2(MAX_BITS + 1);   // holds a size up to MAX_BITS
  localparam int CNT_W      = $clog2(ADDR_BITS);      // divider step counter
  localparam int MIN_SIZE   = 8;
  localparam int OUT_TDATA_W = 8;
  localparam int CMP_W      = (SIZE_W > CFG_W) ? SIZE_W : CFG_W;

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(65536);

  // item kinds carried on the input tuser
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  // size in use: register value clamped to [MIN_SIZE, MAX_BITS]
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] ts);
    logic [CMP_W-1:0] v;
    v = CMP_W'(ts);
    if (v < CMP_W'(MIN_SIZE)) begin
      return SIZE_W'(MIN_SIZE);
    end else if (v > CMP_W'(MAX_BITS)) begin
      return SIZE_W'(MAX_BITS);
    end else begin
      return SIZE_W'(v);
    end
  endfunction

endpackage

// ===== hw/rtl/bloom_filter_address_check.sv =====
// two-hash bloom filter over addresses with a min/max range pre-check
//
// input stream: s_tuser is the item kind (0 insert, 1 query), s_tdata the address.
// output stream: one beat per input beat, m_tdata bit 0 is the present flag
// (1 = possibly present, always 0 for an insert), upper bits zero.
// config: cfg_wen writes cfg_wdata into the table size register at the clock
// edge; the size in use is that value clamped to [8, 65536].
// sequence: two wide adds form the hash products, then the 64-step restoring
// divider reduces both products modulo the size in one pass, then the bit
// store is written (insert) or read (query). the next beat is accepted once
// the result has moved into the output register, so only one item is in work
// at a time.
// reset: rst clears the range bounds and the table size to 65536, then the
// bit store is cleared one entry a cycle; s_tready stays low until that pass
// is over. config writes are taken during that pass.
// stall: the result sits in an output register; a new beat is accepted while
// it waits, and that item holds at its end until the register is free.
module bloom_filter_address_check (
  input  logic                              clk,
  input  logic                              rst,
  // config port
  input  logic                              cfg_wen,
  input  logic [bfac_pkg::CFG_W-1:0]        cfg_wdata,   // table_size
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bfac_pkg::ADDR_FIELD_W-1:0] s_tdata,     // [63:0] address
  input  logic                              s_tuser,     // [0] mode
  // output stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bfac_pkg::OUT_TDATA_W-1:0]  m_tdata      // [0] present, rest zero
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_WR1,
    ST_WR2,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_DONE
  } state_t;

  state_t                         state;
  logic [bfac_pkg::IDX_W-1:0]     clr_idx;
  logic [bfac_pkg::CFG_W-1:0]     table_size;
  logic [bfac_pkg::ADDR_BITS-1:0] lowest;
  logic [bfac_pkg::ADDR_BITS-1:0] highest;
  logic [bfac_pkg::ADDR_BITS-1:0] addr_q;
  logic                           mode_q;
  logic                           in_range;
  logic [bfac_pkg::SIZE_W-1:0]    size_use;
  logic [bfac_pkg::ADDR_BITS-1:0] prod_a;
  logic [bfac_pkg::ADDR_BITS-1:0] prod_b;
  logic                           bit_a;
  logic                           res;
  logic                           present_q;

  logic [bfac_pkg::ADDR_BITS-1:0] addr_in;
  logic                           accept;
  logic                           out_free;
  logic                           div_start;
  logic                           div_done;
  logic [bfac_pkg::IDX_W-1:0]     idx_a;
  logic [bfac_pkg::IDX_W-1:0]     idx_b;
  logic                           ram_we;
  logic [bfac_pkg::IDX_W-1:0]     ram_waddr;
  logic                           ram_wdata;
  logic [bfac_pkg::IDX_W-1:0]     ram_raddr;
  logic                           ram_rdata;

  assign addr_in   = s_tdata[bfac_pkg::ADDR_BITS-1:0];
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign div_start = (state == ST_DIV_GO);
  assign m_tdata   = {{(bfac_pkg::OUT_TDATA_W-1){1'b0}}, present_q};

  // bit store port use: clearing pass writes zeros, inserts write ones
  always_comb begin
    ram_we    = (state == ST_CLEAR) || (state == ST_WR1) || (state == ST_WR2);
    ram_wdata = (state != ST_CLEAR);
    case (state)
      ST_CLEAR: ram_waddr = clr_idx;
      ST_WR1:   ram_waddr = idx_a;
      default:  ram_waddr = idx_b;
    endcase
    ram_raddr = (state == ST_RD1) ? idx_a : idx_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_idx    <= '0;
      table_size <= bfac_pkg::TABLE_SIZE_RST;
      lowest     <= '0;
      highest    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wen) begin
        table_size <= cfg_wdata;
      end
      // the done state reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == bfac_pkg::IDX_W'(bfac_pkg::MAX_BITS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            addr_q   <= addr_in;
            mode_q   <= s_tuser;
            size_use <= bfac_pkg::clamp_size(table_size);
            // range check against the bounds as they stand before this item
            in_range <= !((addr_in < lowest) || (addr_in > highest));
            if (s_tuser == bfac_pkg::MODE_INSERT) begin
              // a zero bound means unset and is always replaced
              if ((lowest == '0) || (addr_in < lowest)) begin
                lowest <= addr_in;
              end
              if ((highest == '0) || (addr_in > highest)) begin
                highest <= addr_in;
              end
            end
            state <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          // addr * 7 = addr * 8 - addr, wrapping at the address width
          prod_a <= {addr_q[bfac_pkg::ADDR_BITS-4:0], 3'b000} - addr_q;
          state  <= ST_MUL2;
        end
        ST_MUL2: begin
          // addr * 13 = (addr * 7) * 2 - addr
          prod_b <= {prod_a[bfac_pkg::ADDR_BITS-2:0], 1'b0} - addr_q;
          state  <= ST_DIV_GO;
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state <= (mode_q == bfac_pkg::MODE_INSERT) ? ST_WR1 : ST_RD1;
          end
        end
        ST_WR1: begin
          state <= ST_WR2;
        end
        ST_WR2: begin
          res   <= 1'b0;
          state <= ST_DONE;
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          bit_a <= ram_rdata;
          state <= ST_RD3;
        end
        ST_RD3: begin
          res   <= in_range && bit_a && ram_rdata;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold until the output register has room
          if (out_free) begin
            m_tvalid  <= 1'b1;
            present_q <= res;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  bfac_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dvd_a   (prod_a),
    .dvd_b   (prod_b),
    .divisor (size_use),
    .done    (div_done),
    .rem_a   (idx_a),
    .rem_b   (idx_b)
  );

  bfac_ram #(
    .WIDTH (1),
    .DEPTH (bfac_pkg::MAX_BITS)
  ) u_bits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // no beat is taken while the store is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !s_tready)
    else $error("input accepted during clearing pass");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider done outside wait state");

  // hashed indices stay below the size in use
  a_idx_in_size: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_WR1) || (state == ST_RD1)) |->
      ((bfac_pkg::SIZE_W'(idx_a) < size_use) && (bfac_pkg::SIZE_W'(idx_b) < size_use)))
    else $error("hash index outside table");

  // once both bounds are set they form a proper range
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    ((lowest != '0) && (highest != '0)) |-> (lowest <= highest))
    else $error("range bounds out of order");

endmodule

// ===== hw/rtl/bfac_ram.sv =====
// generic single write port, single read port ram with registered read
module bfac_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/bfac_div.sv =====
// restoring divider computing two remainders by one divisor in lockstep
module bfac_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bfac_pkg::ADDR_BITS-1:0] dvd_a,
  input  logic [bfac_pkg::ADDR_BITS-1:0] dvd_b,
  input  logic [bfac_pkg::SIZE_W-1:0]    divisor,
  output logic                           done,
  output logic [bfac_pkg::IDX_W-1:0]     rem_a,
  output logic [bfac_pkg::IDX_W-1:0]     rem_b
);

  logic                           busy;
  logic [bfac_pkg::CNT_W-1:0]     cnt;
  logic [bfac_pkg::ADDR_BITS-1:0] sh_a;
  logic [bfac_pkg::ADDR_BITS-1:0] sh_b;
  logic [bfac_pkg::SIZE_W-1:0]    rem_a_q;
  logic [bfac_pkg::SIZE_W-1:0]    rem_b_q;
  logic [bfac_pkg::SIZE_W-1:0]    dsr;
  logic [bfac_pkg::SIZE_W:0]      trial_a;
  logic [bfac_pkg::SIZE_W:0]      trial_b;
  logic [bfac_pkg::SIZE_W:0]      dsr_ext;
  logic [bfac_pkg::SIZE_W:0]      rem_a_next;
  logic [bfac_pkg::SIZE_W:0]      rem_b_next;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    dsr_ext    = {1'b0, dsr};
    trial_a    = {rem_a_q, sh_a[bfac_pkg::ADDR_BITS-1]};
    trial_b    = {rem_b_q, sh_b[bfac_pkg::ADDR_BITS-1]};
    rem_a_next = (trial_a >= dsr_ext) ? (trial_a - dsr_ext) : trial_a;
    rem_b_next = (trial_b >= dsr_ext) ? (trial_b - dsr_ext) : trial_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        sh_a    <= dvd_a;
        sh_b    <= dvd_b;
        rem_a_q <= '0;
        rem_b_q <= '0;
        dsr     <= divisor;
      end else if (busy) begin
        sh_a    <= {sh_a[bfac_pkg::ADDR_BITS-2:0], 1'b0};
        sh_b    <= {sh_b[bfac_pkg::ADDR_BITS-2:0], 1'b0};
        rem_a_q <= rem_a_next[bfac_pkg::SIZE_W-1:0];
        rem_b_q <= rem_b_next[bfac_pkg::SIZE_W-1:0];
        cnt     <= cnt + 1'b1;
        if (cnt == bfac_pkg::CNT_W'(bfac_pkg::ADDR_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder is below the divisor, which never exceeds the store size
  assign rem_a = rem_a_q[bfac_pkg::IDX_W-1:0];
  assign rem_b = rem_b_q[bfac_pkg::IDX_W-1:0];

endmodule

// ===== verif/bfac_presence_checker.sv =====
// checker: predicts the present flag of every input beat and compares the result beats
module bfac_presence_checker
  import bfac_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wen,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [ADDR_FIELD_W-1:0] s_tdata,
  input  logic                    s_tuser,
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [OUT_TDATA_W-1:0]  m_tdata,
  output int                      mismatch_count,
  output int                      results_owed
);

  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

  bit               filter_store [MAX_BITS];
  logic [63:0]      low_bound;
  logic [63:0]      high_bound;
  logic [CFG_W-1:0] table_size;
  logic             present_q [$];
  logic             owed_present;
  int               errs = 0;

  function automatic logic [63:0] clamped_size(input logic [CFG_W-1:0] ts);
    if (64'(ts) < 64'(MIN_SIZE)) begin
      return 64'(MIN_SIZE);
    end else if (64'(ts) > 64'(MAX_BITS)) begin
      return 64'(MAX_BITS);
    end
    return 64'(ts);
  endfunction

  function automatic int hashed_index(input logic [63:0] a, input logic [63:0] mul,
                                      input logic [63:0] size);
    logic [63:0] prod;
    prod = (a * mul) & ADDR_MASK;
    return int'(prod % size);
  endfunction

  // updates the filter state for one item and returns its present flag
  function automatic logic predict_present(input logic mode, input logic [63:0] raw_addr);
    logic [63:0] a;
    logic [63:0] size;
    int          i1;
    int          i2;
    a    = raw_addr & ADDR_MASK;
    size = clamped_size(table_size);
    i1   = hashed_index(a, 64'd7, size);
    i2   = hashed_index(a, 64'd13, size);
    if (mode == MODE_INSERT) begin
      // a zero bound reads as unset
      if (low_bound == '0 || a < low_bound) low_bound = a;
      if (high_bound == '0 || a > high_bound) high_bound = a;
      filter_store[i1] = 1'b1;
      filter_store[i2] = 1'b1;
      return 1'b0;
    end
    if (a < low_bound || a > high_bound) return 1'b0;
    return filter_store[i1] & filter_store[i2];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (filter_store[i]) filter_store[i] = 1'b0;
      low_bound  = '0;
      high_bound = '0;
      table_size = TABLE_SIZE_RST;
      present_q.delete();
    end else begin
      if (cfg_wen) table_size = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (present_q.size() == 0) begin
          $error("result beat with no prediction waiting, m_tdata %0h", m_tdata);
          errs++;
        end else begin
          owed_present = present_q.pop_front();
          if (m_tdata[0] !== owed_present) begin
            $error("present: expected %0b, actual %0b", owed_present, m_tdata[0]);
            errs++;
          end
          if (m_tdata[OUT_TDATA_W-1:1] !== '0) begin
            $error("m_tdata pad: expected 0, actual %0h", m_tdata[OUT_TDATA_W-1:1]);
            errs++;
          end
        end
      end
      if (s_tvalid && s_tready) present_q.push_back(predict_present(s_tuser, s_tdata));
    end
    mismatch_count <= errs;
    results_owed   <= present_q.size();
  end

endmodule

// ===== verif/bloom_filter_address_check_tb.sv =====
// testbench top: stimulus, config phases and verdict for the bloom filter address check
module bloom_filter_address_check_tb;
  import bfac_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int PHASE_ITEMS = 110;     // random items per table size phase
  localparam int NUM_PHASES  = 10;
  localparam int RANDOM_PHASE = 8;      // phase whose size is drawn at random
  localparam int QUIET_PHASE  = 3;      // phase without any idling on either side
  localparam int POOL_DEPTH   = 64;     // recent inserted addresses kept for hits

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wen = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [ADDR_FIELD_W-1:0] s_tdata = '0;    // [63:0] address
  logic                    s_tuser = 1'b0;  // [0] mode
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;         // [0] present, rest zero
  int                      mismatch_count;
  int                      results_owed;
  bit                      no_idle = 1'b0;

  logic [63:0]             inserted_q [$];

  // table sizes per phase, clamp edges on both sides included
  logic [CFG_W-1:0] size_plan [NUM_PHASES] = '{
    CFG_W'(8), CFG_W'(0), CFG_W'(131071), CFG_W'(1000), CFG_W'(65537),
    CFG_W'(7), CFG_W'(13), CFG_W'(65535), CFG_W'(0), CFG_W'(65536)
  };

  always #(CLK_PERIOD / 2) clk = ~clk;

  bloom_filter_address_check dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  bfac_presence_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wen        (cfg_wen),
    .cfg_wdata      (cfg_wdata),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  // result side back-pressure, about 14 stalled cycles in a hundred
  always @(posedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  // one input beat; tvalid stays high after the accept so back-to-back beats
  // need no second assignment in the same step
  task automatic send_beat(input logic mode, input logic [63:0] addr);
    // random gap of random length so the beat arrives at varied points in the block's work
    if (!no_idle && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= addr;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode == MODE_INSERT) begin
      inserted_q.push_back(addr);
      if (inserted_q.size() > POOL_DEPTH) void'(inserted_q.pop_front());
    end
  endtask

  // drop tvalid and wait until every predicted beat has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [CFG_W-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
  endtask

  // wide random, small, near the top, and a few corner addresses
  function automatic logic [63:0] random_address();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return {$urandom(), $urandom()};
    if (r < 75) return 64'($urandom_range(0, 4095));
    if (r < 90) return ~64'($urandom_range(0, 4095));
    case ($urandom_range(0, 2))
      0:       return 64'd0;
      1:       return {64{1'b1}};
      default: return 64'd1 << $urandom_range(0, 63);
    endcase
  endfunction

  // mostly inserts and queries of known addresses, the rest misses and neighbors
  task automatic random_item();
    int          r;
    logic [63:0] known;
    r = $urandom_range(0, 99);
    if (r < 40 || inserted_q.size() == 0) begin
      send_beat(MODE_INSERT, random_address());
    end else begin
      known = inserted_q[$urandom_range(0, inserted_q.size() - 1)];
      if (r < 75) begin
        send_beat(MODE_QUERY, known);
      end else if (r < 90) begin
        send_beat(MODE_QUERY, random_address());
      end else begin
        send_beat(MODE_QUERY, known + 64'($urandom_range(0, 16)) - 64'd8);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset table size
    send_beat(MODE_QUERY, 64'd0);                  // query before any insert
    send_beat(MODE_QUERY, 64'd5);
    send_beat(MODE_INSERT, 64'd0);                 // zero insert leaves bounds unset
    send_beat(MODE_QUERY, 64'd0);
    send_beat(MODE_INSERT, 64'h1000);              // overwrites the unset bounds
    send_beat(MODE_QUERY, 64'd0);                  // now below the range
    send_beat(MODE_QUERY, 64'h1000);
    send_beat(MODE_QUERY, 64'h1001);               // above the range
    send_beat(MODE_INSERT, {64{1'b1}});
    send_beat(MODE_INSERT, 64'd1);
    send_beat(MODE_QUERY, {64{1'b1}});
    send_beat(MODE_QUERY, 64'd1);
    send_beat(MODE_QUERY, 64'd2);
    send_beat(MODE_INSERT, 64'h8000_0000_0000_0000);  // both products wrap
    send_beat(MODE_QUERY, 64'h8000_0000_0000_0000);
    send_beat(MODE_INSERT, 64'h2492_4924_9249_2493);
    send_beat(MODE_QUERY, 64'h2492_4924_9249_2493);
    send_beat(MODE_QUERY, 64'h5555_5555_5555_5555);
    send_beat(MODE_QUERY, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(MODE_INSERT, 64'd0);                 // low bound back to unset
    send_beat(MODE_QUERY, 64'd0);
    send_beat(MODE_INSERT, 64'hFFFF_0000_0000_0000);
    send_beat(MODE_QUERY, 64'd1);                  // below the new low bound

    // random phases, each under its own table size; stored bits carry over
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      write_table_size(p == RANDOM_PHASE ? CFG_W'($urandom_range(9, 131070)) : size_plan[p]);
      no_idle = (p == QUIET_PHASE);
      repeat (PHASE_ITEMS) random_item();
    end
    no_idle = 1'b0;

    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("** bloom_filter_address_check: PASSED **");
    end else begin
      $display("** bloom_filter_address_check: FAILED **");
    end
    $finish;
  end

  // hang guard, well beyond the clearing pass plus all items at full stall
  initial begin
    #(CLK_PERIOD * 1_500_000);
    $display("** bloom_filter_address_check: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/bfac_pkg.sv
hw/rtl/bfac_ram.sv
hw/rtl/bfac_div.sv
hw/rtl/bloom_filter_address_check.sv
verif/bfac_presence_checker.sv
verif/bloom_filter_address_check_tb.sv
